FILE: hdl/ffla_pkg.sv
// ffla_pkg: shared constants and codes for the first-fit free-list allocator
// no dependencies; imported by first_fit_free_list_allocator_top
package ffla_pkg;

  localparam int REQ_W        = 17;
  localparam int ADDR_W       = 16;
  localparam int CHUNK_W      = 17;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 8;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ARENA  = 2'd1;
  localparam logic [1:0] ST_TFULL  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CHUNK = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_PROC = 6'b000100,
    S_END  = 6'b001000,
    S_GROW = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

endpackage

FILE: hdl/first_fit_free_list_allocator_top.sv
// Allocator with an address-ordered free-extent table, ping-pong banked in one RAM,
// and a per-header size store RAM. Depends on ffla_pkg.
//
// Each word is handled alone; in_ready_o is high only between words. An allocate
// word streams the free-extent table once (a read state and a process state per
// entry, set by the single registered read port of the extent RAM), copying it
// into the other bank while it finds and splits or removes the first fit. If
// nothing fits, the arena can grow and the table has room, a grow state appends
// the new extent and a second pass follows. A free word reads its kept size and
// makes one pass that inserts and merges in the same stream. The result goes to
// an output register, so the next word may be taken while it waits. Bad free
// addresses and a free into a full table skip the pass and go to the response.
module first_fit_free_list_allocator_top
  import ffla_pkg::*;
#(
  parameter int ARENA_BYTES = 65536,
  parameter int MAX_EXTENTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [REQ_W-1:0]  request_size_i,
  input  logic [ADDR_W-1:0] block_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] user_address_o,
  output logic [1:0]        status_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW          = $clog2(ARENA_BYTES + 1);
  localparam int DW          = ((SW > REQ_W) ? SW : REQ_W) + 2;
  localparam int IW          = $clog2(MAX_EXTENTS);
  localparam int CW          = $clog2(MAX_EXTENTS + 1);
  localparam int EDEPTH      = 2 * (2 ** IW);
  localparam int STORE_DEPTH = ARENA_BYTES / 8;
  localparam int SIW         = $clog2(STORE_DEPTH);

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
  } ext_t;

  // memories
  ext_t          ext_mem [EDEPTH];
  ext_t          ext_rd_q;
  logic          ext_re;
  logic [IW:0]   ext_raddr;
  logic          ext_we;
  logic [IW:0]   ext_waddr;
  ext_t          ext_wdata;

  logic [SW-1:0] hs_mem [STORE_DEPTH];
  logic [SW-1:0] hs_rd_q;
  logic          hs_re;
  logic [SIW-1:0] hs_raddr;
  logic          hs_we;
  logic [SIW-1:0] hs_waddr;
  logic [SW-1:0] hs_wdata;

  always_ff @(posedge clk_i) begin
    if (ext_we) begin
      ext_mem[ext_waddr] <= ext_wdata;
    end
    if (ext_re) begin
      ext_rd_q <= ext_mem[ext_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_we) begin
      hs_mem[hs_waddr] <= hs_wdata;
    end
    if (hs_re) begin
      hs_rd_q <= hs_mem[hs_raddr];
    end
  end

  // control and working registers
  state_e            state_q;
  logic              kind_q;
  logic [REQ_W-1:0]  req_q;
  logic [SW-1:0]     hdr_q;
  logic              bank_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     wcnt_q;
  logic              found_q;
  logic              second_q;
  logic              inserted_q;
  logic              have_cur_q;
  logic [SW-1:0]     cur_start_q;
  logic [SW-1:0]     cur_size_q;
  logic [DW-1:0]     cur_end_q;
  logic [SW-1:0]     hwm_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [ADDR_W-1:0] res_user_q;
  logic [1:0]        res_status_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_user_q;
  logic [1:0]        out_status_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // free address checks on the incoming word
  logic [DW-1:0] f_addr_x;
  logic [DW-1:0] f_hdr_x;
  logic          f_bad;
  assign f_addr_x = DW'(block_address_i);
  assign f_hdr_x  = f_addr_x - DW'(HEADER_BYTES);
  assign f_bad    = (f_addr_x < DW'(HEADER_BYTES)) || (f_hdr_x >= DW'(ARENA_BYTES));

  // allocate datapath on the entry just read
  ext_t          e;
  logic [DW-1:0] a_sz, a_req, a_end, a_rem, a_nb, a_newsz;
  logic [2:0]    a_pad;
  logic          a_fit, a_take, a_drop;
  assign e        = ext_rd_q;
  assign a_sz     = DW'(e.size);
  assign a_req    = DW'(req_q);
  assign a_end    = DW'(e.start) + a_req + DW'(HEADER_BYTES);
  assign a_pad    = 3'd0 - a_end[2:0];
  assign a_fit    = a_sz >= a_req;
  assign a_take   = a_fit && !found_q;
  assign a_rem    = a_sz - a_req;
  assign a_drop   = a_rem < (DW'(HEADER_BYTES) + DW'(a_pad));
  assign a_nb     = a_end + DW'(a_pad);
  assign a_newsz  = a_rem - DW'(HEADER_BYTES) - DW'(a_pad);

  // growth datapath
  logic [DW-1:0] g_growth, g_total, g_hdr, g_size;
  logic [2:0]    g_pad;
  logic          g_over;
  assign g_growth = DW'(chunk_q) + a_req + DW'(ALIGN_BYTES);
  assign g_over   = (DW'(hwm_q) + g_growth) > DW'(ARENA_BYTES);
  assign g_pad    = 3'd0 - hwm_q[2:0];
  assign g_hdr    = DW'(hwm_q) + DW'(g_pad);
  assign g_total  = DW'(chunk_q) + a_req;
  assign g_size   = (g_total >= DW'(HEADER_BYTES) + DW'(g_pad)) ?
                    (g_total - DW'(HEADER_BYTES) - DW'(g_pad)) : '0;

  // free: insert-and-merge stream
  ext_t          new_ext;
  ext_t          feed;
  logic          f_sel_new, feed_en, f_merge, f_flush;
  logic [DW-1:0] f_end, f_merged;
  assign new_ext.start = hdr_q;
  assign new_ext.size  = hs_rd_q;
  assign f_sel_new = (state_q == S_END) || (!inserted_q && (e.start >= hdr_q));
  assign feed      = f_sel_new ? new_ext : e;
  assign feed_en   = (kind_q == KIND_FREE) &&
                     ((state_q == S_PROC) || ((state_q == S_END) && !inserted_q));
  assign f_flush   = (kind_q == KIND_FREE) && (state_q == S_END) && inserted_q;
  assign f_end     = DW'(feed.start) + DW'(feed.size) + DW'(HEADER_BYTES);
  assign f_merged  = DW'(feed.start) + DW'(feed.size) - DW'(cur_start_q);
  assign f_merge   = have_cur_q && (DW'(feed.start) >= cur_end_q) &&
                     ((DW'(feed.start) - cur_end_q) < DW'(ALIGN_BYTES));

  logic alloc_proc;
  assign alloc_proc = (kind_q == KIND_ALLOC) && (state_q == S_PROC);

  // memory port steering
  always_comb begin
    ext_re    = (state_q == S_RD) && (idx_q != count_q);
    ext_raddr = {bank_q, idx_q[IW-1:0]};
    ext_we    = 1'b0;
    ext_waddr = {~bank_q, wcnt_q[IW-1:0]};
    ext_wdata = e;
    hs_re     = in_acc && (kind_i == KIND_FREE);
    hs_raddr  = f_hdr_x[SIW+2:3];
    hs_we     = 1'b0;
    hs_waddr  = e.start[SIW+2:3];
    hs_wdata  = a_drop ? e.size : SW'(req_q);
    if (alloc_proc) begin
      ext_we = !(a_take && a_drop);
      if (a_take) begin
        ext_wdata.start = SW'(a_nb);
        ext_wdata.size  = SW'(a_newsz);
      end
      hs_we = a_take && (DW'(e.start) < DW'(ARENA_BYTES));
    end else if ((feed_en && !f_merge && have_cur_q) || f_flush) begin
      ext_we          = 1'b1;
      ext_wdata.start = cur_start_q;
      ext_wdata.size  = cur_size_q;
    end else if (state_q == S_GROW) begin
      ext_we          = 1'b1;
      ext_waddr       = {bank_q, count_q[IW-1:0]};
      ext_wdata.start = SW'(g_hdr);
      ext_wdata.size  = SW'(g_size);
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_ALLOC;
      req_q        <= '0;
      hdr_q        <= '0;
      bank_q       <= 1'b0;
      count_q      <= '0;
      idx_q        <= '0;
      wcnt_q       <= '0;
      found_q      <= 1'b0;
      second_q     <= 1'b0;
      inserted_q   <= 1'b0;
      have_cur_q   <= 1'b0;
      cur_start_q  <= '0;
      cur_size_q   <= '0;
      cur_end_q    <= '0;
      hwm_q        <= '0;
      res_user_q   <= '0;
      res_status_q <= ST_OK;
    end else begin
      if (ext_we) begin
        if (state_q != S_GROW) begin
          wcnt_q <= wcnt_q + 1'b1;
        end
      end
      if (feed_en) begin
        if (f_sel_new) begin
          inserted_q <= 1'b1;
        end
        if (f_merge) begin
          cur_size_q <= SW'(f_merged);
          cur_end_q  <= f_end;
        end else begin
          cur_start_q <= feed.start;
          cur_size_q  <= feed.size;
          cur_end_q   <= f_end;
          have_cur_q  <= 1'b1;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q     <= kind_i;
            req_q      <= request_size_i;
            hdr_q      <= SW'(f_hdr_x);
            idx_q      <= '0;
            wcnt_q     <= '0;
            found_q    <= 1'b0;
            second_q   <= 1'b0;
            inserted_q <= 1'b0;
            have_cur_q <= 1'b0;
            res_user_q <= '0;
            if (kind_i == KIND_FREE && f_bad) begin
              res_status_q <= ST_OK;
              state_q      <= S_RESP;
            end else if (kind_i == KIND_FREE && count_q >= CW'(MAX_EXTENTS)) begin
              res_status_q <= ST_TFULL;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          if (idx_q == count_q) begin
            state_q <= S_END;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_PROC;
          end
        end
        S_PROC: begin
          if (kind_q == KIND_ALLOC) begin
            if (a_take) begin
              found_q    <= 1'b1;
              res_user_q <= ADDR_W'(DW'(e.start) + DW'(HEADER_BYTES));
            end
            state_q <= S_RD;
          end else if (!f_sel_new) begin
            state_q <= S_RD;
          end
        end
        S_END: begin
          if (kind_q == KIND_ALLOC) begin
            bank_q  <= ~bank_q;
            count_q <= wcnt_q;
            if (found_q) begin
              res_status_q <= ST_OK;
              state_q      <= S_RESP;
            end else if (second_q || g_over) begin
              res_user_q   <= '0;
              res_status_q <= ST_ARENA;
              state_q      <= S_RESP;
            end else if (wcnt_q >= CW'(MAX_EXTENTS)) begin
              res_user_q   <= '0;
              res_status_q <= ST_TFULL;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_GROW;
            end
          end else if (inserted_q) begin
            // last extent written, table now lives in the other bank
            bank_q       <= ~bank_q;
            count_q      <= wcnt_q + 1'b1;
            res_user_q   <= '0;
            res_status_q <= ST_OK;
            state_q      <= S_RESP;
          end
        end
        S_GROW: begin
          count_q  <= count_q + 1'b1;
          hwm_q    <= SW'(DW'(hwm_q) + g_growth);
          second_q <= 1'b1;
          idx_q    <= '0;
          wcnt_q   <= '0;
          state_q  <= S_RD;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_user_q   <= '0;
      out_status_q <= ST_OK;
    end else if (state_q == S_RESP && (!out_valid_q || out_ready_i)) begin
      out_valid_q  <= 1'b1;
      out_user_q   <= res_user_q;
      out_status_q <= res_status_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign user_address_o = out_user_q;
  assign status_o       = out_status_q;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHUNK)) begin
      chunk_q <= pwdata[CHUNK_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CHUNK) ? 32'(chunk_q) : 32'd0;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EXTENTS))
    else $error("extent count above table depth");

  a_write_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_PROC) |-> wcnt_q <= idx_q)
    else $error("copy stream writes ahead of reads");

  a_hwm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DW'(hwm_q) <= DW'(ARENA_BYTES))
    else $error("high-water mark beyond arena");

  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GROW) |-> (count_q < CW'(MAX_EXTENTS) && !g_over))
    else $error("growth without room");
`endif

endmodule
